FILE: rtl/tvsc_pkg.sv
// ----------------------------------------------------------------------------
// tvsc_pkg
// Shared types, constants and conversion functions for the tile viewport
// scroll clamp unit.
// ----------------------------------------------------------------------------
package tvsc_pkg;

  // grid and tile geometry
  localparam int TILE_W    = 16;
  localparam int TILE_H    = 16;
  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int VIS_COLS  = 20;
  localparam int VIS_ROWS  = 15;

  // coordinate widths
  localparam int TW = 8;
  localparam int PW = 12;

  // reciprocal constants for pixel to tile conversion
  localparam int DIV_SHIFT  = 24;
  localparam int RECIP_BITS = DIV_SHIFT + 1;
  localparam int PROD_BITS  = PW + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP_W =
    RECIP_BITS'(((2 ** DIV_SHIFT) + TILE_W - 1) / TILE_W);
  localparam logic [RECIP_BITS-1:0] RECIP_H =
    RECIP_BITS'(((2 ** DIV_SHIFT) + TILE_H - 1) / TILE_H);

  // operation codes
  typedef enum logic [1:0] {
    FUNC_SET_LIMIT = 2'd0,
    FUNC_SET_VIEW  = 2'd1,
    FUNC_MOVE      = 2'd2
  } func_t;

  typedef struct packed {
    logic [1:0]           func;
    logic signed [TW-1:0] min_col;
    logic signed [TW-1:0] min_row;
    logic signed [TW-1:0] max_col;
    logic signed [TW-1:0] max_row;
    logic signed [TW-1:0] step_x;
    logic signed [TW-1:0] step_y;
  } req_t;

  typedef struct packed {
    logic signed [TW-1:0] view_min_col;
    logic signed [TW-1:0] view_min_row;
    logic signed [TW-1:0] view_max_col;
    logic signed [TW-1:0] view_max_row;
    logic signed [PW-1:0] screen_min_x;
    logic signed [PW-1:0] screen_min_y;
    logic signed [PW-1:0] screen_max_x;
    logic signed [PW-1:0] screen_max_y;
    logic                 accepted;
  } rsp_t;

  typedef struct packed {
    logic signed [TW-1:0] tile_left;
    logic signed [TW-1:0] tile_top;
    logic signed [TW-1:0] tile_right;
    logic signed [TW-1:0] tile_bottom;
    logic signed [PW-1:0] pix_left;
    logic signed [PW-1:0] pix_top;
    logic signed [PW-1:0] pix_right;
    logic signed [PW-1:0] pix_bottom;
    logic signed [TW-1:0] limit_left;
    logic signed [TW-1:0] limit_top;
    logic signed [TW-1:0] limit_right;
    logic signed [TW-1:0] limit_bottom;
    logic signed [TW-1:0] view_width;
    logic signed [TW-1:0] view_height;
  } view_state_t;

  localparam view_state_t STATE_RESET = '{
    tile_left:    '0,
    tile_top:     '0,
    tile_right:   TW'(VIS_COLS - 1),
    tile_bottom:  TW'(VIS_ROWS - 1),
    pix_left:     '0,
    pix_top:      '0,
    pix_right:    PW'(VIS_COLS * TILE_W),
    pix_bottom:   PW'(VIS_ROWS * TILE_H),
    limit_left:   '0,
    limit_top:    '0,
    limit_right:  TW'(GRID_COLS),
    limit_bottom: TW'(GRID_ROWS),
    view_width:   TW'(VIS_COLS - 1),
    view_height:  TW'(VIS_ROWS - 1)
  };

  // tile coordinate to pixel coordinate, wrapped to pixel width
  function automatic logic signed [PW-1:0] tile_to_pix(
    input logic signed [TW-1:0] t,
    input int                   scale
  );
    logic signed [2*TW-1:0] p;
    p = (2*TW)'(t) * (2*TW)'(scale);
    return p[PW-1:0];
  endfunction

  // pixel to tile, truncating toward zero, by reciprocal multiply
  function automatic logic signed [TW-1:0] pix_to_tile(
    input logic signed [PW-1:0]  p,
    input logic [RECIP_BITS-1:0] recip
  );
    logic [PW-1:0]        mag;
    logic [PROD_BITS-1:0] prod;
    logic [PW-1:0]        q;
    logic [PW-1:0]        s;
    mag  = p[PW-1] ? (~p + PW'(1)) : p;
    prod = PROD_BITS'(mag) * PROD_BITS'(recip);
    q    = prod[DIV_SHIFT +: PW];
    s    = p[PW-1] ? (~q + PW'(1)) : q;
    return s[TW-1:0];
  endfunction

endpackage

FILE: rtl/tile_viewport_scroll_clamp_unit.sv
// ----------------------------------------------------------------------------
// tile_viewport_scroll_clamp_unit
// Scrolling viewport over a tile grid, clamped to a limit rectangle.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------
//   req     | in        | req_valid / req_ready  | req_t
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_t
//
// One request per cycle while the output is not stalled; a request passes
// through the input register, then the result register, before its response leaves.
// The view state updates in the same cycle the response register loads, so the
// next request sees it with no bubble.
// A stalled response holds the result register; one more request can wait in
// the input register, after which req_ready drops.
// Synchronous reset restores the default view, limits and view size.
// ----------------------------------------------------------------------------
module tile_viewport_scroll_clamp_unit
  import tvsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic        req_q_valid;
  req_t        req_q;
  view_state_t st;
  view_state_t st_next;
  rsp_t        rsp_next;
  logic        advance;

  // request moves into the result register when that register is free or its response is taken
  assign advance   = req_q_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !req_q_valid || advance;

  tvsc_step u_step (
    .req     (req_q),
    .st      (st),
    .st_next (st_next),
    .rsp     (rsp_next)
  );

  // control and view state
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
      rsp_valid   <= 1'b0;
      st          <= STATE_RESET;
    end else begin
      if (req_ready) begin
        req_q_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
        st        <= st_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: rtl/tvsc_step.sv
// ----------------------------------------------------------------------------
// tvsc_step
// Next view state and response for one request: set limit, set view or move.
// ----------------------------------------------------------------------------
module tvsc_step
  import tvsc_pkg::*;
(
  input  req_t        req,
  input  view_state_t st,
  output view_state_t st_next,
  output rsp_t        rsp
);

  localparam logic signed [9:0]  GRID_COLS_S = 10'(GRID_COLS);
  localparam logic signed [9:0]  GRID_ROWS_S = 10'(GRID_ROWS);
  localparam logic signed [10:0] VIS_COLS_S  = 11'(VIS_COLS);
  localparam logic signed [10:0] VIS_ROWS_S  = 11'(VIS_ROWS);

  typedef struct packed {
    logic signed [TW-1:0] lo;
    logic signed [TW-1:0] hi;
  } span_t;

  // grow a limit span so that it covers the view size
  function automatic span_t widen(
    input logic signed [TW-1:0] lo,
    input logic signed [TW-1:0] hi,
    input logic signed [TW-1:0] size
  );
    span_t               s;
    logic signed [9:0]   diff;
    logic signed [9:0]   hs;
    s.lo = lo;
    s.hi = hi;
    diff = 10'(hi) - 10'(lo);
    hs   = 10'(hi) - 10'(size);
    if (diff < 10'(size)) begin
      if (hs >= 10'sd0) begin
        s.lo = hs[TW-1:0];
      end else begin
        s.lo = '0;
        s.hi = size;
      end
    end
    return s;
  endfunction

  // set limit
  logic signed [9:0]    lim_c1, lim_d1;
  logic                 lim_ok;
  logic signed [TW-1:0] lim_l0, lim_t0, lim_r0, lim_b0;
  span_t                lim_x, lim_y;

  always_comb begin
    lim_c1 = 10'(req.max_col) + 10'sd1;
    lim_d1 = 10'(req.max_row) + 10'sd1;
    lim_ok = (10'(req.min_col) < GRID_COLS_S) && (req.min_col >= 8'sd0) &&
             (lim_c1 <= GRID_COLS_S) && (lim_c1 >= 10'sd0) &&
             (10'(req.min_row) < GRID_ROWS_S) && (req.min_row >= 8'sd0) &&
             (lim_d1 <= GRID_ROWS_S) && (lim_d1 >= 10'sd0);
    lim_l0 = lim_ok ? req.min_col : '0;
    lim_t0 = lim_ok ? req.min_row : '0;
    lim_r0 = lim_ok ? lim_c1[TW-1:0] : TW'(GRID_COLS);
    lim_b0 = lim_ok ? lim_d1[TW-1:0] : TW'(GRID_ROWS);
    lim_x  = widen(lim_l0, lim_r0, st.view_width);
    lim_y  = widen(lim_t0, lim_b0, st.view_height);
  end

  // set view with clamping into the limits
  logic signed [10:0]   sv_l, sv_r, sv_t, sv_b;
  logic signed [10:0]   ll, lt, lr, lb;
  logic                 sv_ok;
  logic signed [TW-1:0] sv_tl, sv_tt, sv_tr, sv_tb;

  always_comb begin
    ll   = 11'(st.limit_left);
    lt   = 11'(st.limit_top);
    lr   = 11'(st.limit_right);
    lb   = 11'(st.limit_bottom);
    sv_l = 11'(req.min_col);
    sv_t = 11'(req.min_row);
    sv_r = 11'(req.max_col) + 11'sd1;
    sv_b = 11'(req.max_row) + 11'sd1;
    sv_ok = (sv_l <= lr) && (sv_l >= ll) && (sv_r <= lr) && (sv_r >= ll) &&
            (sv_t <= lb) && (sv_t >= lt) && (sv_b <= lb) && (sv_b >= lt);
    if (!sv_ok) begin
      if (sv_l < ll) begin
        sv_l = ll;
        sv_r = ll + VIS_COLS_S;
      end
      if (sv_r > lr) begin
        sv_l = lr - VIS_COLS_S;
        sv_r = lr;
      end
      if (sv_t < lt) begin
        sv_t = lt;
        sv_b = lt + VIS_ROWS_S;
      end
      if (sv_b > lb) begin
        sv_t = lb - VIS_ROWS_S;
        sv_b = lb;
      end
    end
    sv_tl = sv_l[TW-1:0];
    sv_tt = sv_t[TW-1:0];
    sv_tr = sv_r[TW-1:0];
    sv_tb = sv_b[TW-1:0];
  end

  // move by pixels, taken only when all edges stay inside the limits
  logic signed [15:0]   xlo, xhi, ylo, yhi;
  logic signed [15:0]   mv_l, mv_r, mv_t, mv_b;
  logic                 mv_ok;
  logic signed [PW-1:0] mv_pl, mv_pr, mv_pt, mv_pb;

  always_comb begin
    xlo   = 16'(st.limit_left)   * 16'(TILE_W);
    xhi   = 16'(st.limit_right)  * 16'(TILE_W);
    ylo   = 16'(st.limit_top)    * 16'(TILE_H);
    yhi   = 16'(st.limit_bottom) * 16'(TILE_H);
    mv_l  = 16'(st.pix_left)   + 16'(req.step_x);
    mv_r  = 16'(st.pix_right)  + 16'(req.step_x);
    mv_t  = 16'(st.pix_top)    + 16'(req.step_y);
    mv_b  = 16'(st.pix_bottom) + 16'(req.step_y);
    mv_ok = (mv_l <= xhi) && (mv_l >= xlo) && (mv_r <= xhi) && (mv_r >= xlo) &&
            (mv_t <= yhi) && (mv_t >= ylo) && (mv_b <= yhi) && (mv_b >= ylo);
    mv_pl = mv_l[PW-1:0];
    mv_pr = mv_r[PW-1:0];
    mv_pt = mv_t[PW-1:0];
    mv_pb = mv_b[PW-1:0];
  end

  // select by operation
  logic ok;

  always_comb begin
    st_next = st;
    ok      = 1'b0;
    case (req.func)
      FUNC_SET_LIMIT: begin
        ok                   = lim_ok;
        st_next.limit_left   = lim_x.lo;
        st_next.limit_right  = lim_x.hi;
        st_next.limit_top    = lim_y.lo;
        st_next.limit_bottom = lim_y.hi;
      end
      FUNC_SET_VIEW: begin
        ok                  = sv_ok;
        st_next.tile_left   = sv_tl;
        st_next.tile_top    = sv_tt;
        st_next.tile_right  = sv_tr;
        st_next.tile_bottom = sv_tb;
        st_next.pix_left    = tile_to_pix(sv_tl, TILE_W);
        st_next.pix_top     = tile_to_pix(sv_tt, TILE_H);
        st_next.pix_right   = tile_to_pix(sv_tr, TILE_W);
        st_next.pix_bottom  = tile_to_pix(sv_tb, TILE_H);
        st_next.view_width  = sv_tr - sv_tl;
        st_next.view_height = sv_tb - sv_tt;
      end
      FUNC_MOVE: begin
        ok = mv_ok;
        if (mv_ok) begin
          st_next.pix_left    = mv_pl;
          st_next.pix_right   = mv_pr;
          st_next.pix_top     = mv_pt;
          st_next.pix_bottom  = mv_pb;
          st_next.tile_left   = pix_to_tile(mv_pl, RECIP_W);
          st_next.tile_right  = pix_to_tile(mv_pr, RECIP_W);
          st_next.tile_top    = pix_to_tile(mv_pt, RECIP_H);
          st_next.tile_bottom = pix_to_tile(mv_pb, RECIP_H);
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // response carries the view after the update
  assign rsp = '{
    view_min_col: st_next.tile_left,
    view_min_row: st_next.tile_top,
    view_max_col: st_next.tile_right,
    view_max_row: st_next.tile_bottom,
    screen_min_x: st_next.pix_left,
    screen_min_y: st_next.pix_top,
    screen_max_x: st_next.pix_right,
    screen_max_y: st_next.pix_bottom,
    accepted:     ok
  };

endmodule

FILE: rtl/tvsc_checker.sv
// ----------------------------------------------------------------------------
// tvsc_checker
// Port-level checks for the tile viewport scroll clamp unit, bound to the top.
// ----------------------------------------------------------------------------
module tvsc_checker
  import tvsc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // reset empties the response register
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // a fresh response comes from a request that passed the input and result registers
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
    else $error("response without request");

  // a request taken under a stall fills the input register
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready && $past(rsp_valid && !rsp_ready) &&
    $past(req_valid && req_ready) |-> !req_ready)
    else $error("ready high with both registers full");

endmodule

bind tile_viewport_scroll_clamp_unit tvsc_checker u_tvsc_checker (.*);
